>>> rtl/etp_pkg.sv
// Shared types, constants and keyword tables for the entity text parser.
// Depends on nothing; every other file in rtl imports it.
package etp_pkg;

   localparam int NameLimitDefault = 255;
   localparam int ReqDataW         = 8;
   localparam int RspDataW         = 152;
   localparam int RspUserW         = 2;
   localparam int MagW             = 31;

   localparam logic [MagW-1:0] NumMax = {MagW{1'b1}};

   localparam logic [7:0] ChOpenBrace  = 8'h7B;
   localparam logic [7:0] ChCloseBrace = 8'h7D;
   localparam logic [7:0] ChQuote      = 8'h22;
   localparam logic [7:0] ChSpace      = 8'h20;
   localparam logic [7:0] ChPlus       = 8'h2B;
   localparam logic [7:0] ChMinus      = 8'h2D;
   localparam logic [7:0] LenMax       = 8'hFF;

   // Parser position, one-hot.
   typedef enum logic [2:0] {
      PH_OUT = 3'b001,
      PH_ENT = 3'b010,
      PH_STR = 3'b100
   } phase_type;

   // Integer reader position, one-hot.
   typedef enum logic [3:0] {
      NUM_SKIP  = 4'b0001,
      NUM_SIGN  = 4'b0010,
      NUM_DIGIT = 4'b0100,
      NUM_DONE  = 4'b1000
   } num_phase_type;

   // Key codes; the first three double as keyword indexes.
   typedef enum logic [1:0] {
      KEY_CLASS  = 2'd0,
      KEY_ORIGIN = 2'd1,
      KEY_ANGLE  = 2'd2,
      KEY_NONE   = 2'd3
   } key_type;

   typedef enum logic [1:0] {
      KIND_NAME_BEGIN = 2'd0,
      KIND_NAME_BYTE  = 2'd1,
      KIND_ENTITY     = 2'd2
   } kind_type;

   typedef struct packed {
      num_phase_type   phase;
      logic            negative;
      logic [MagW-1:0] magnitude;
   } num_state_type;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   name_char;
      logic [7:0]   name_index;
      logic [31:0]  origin_x;
      logic [31:0]  origin_y;
      logic [31:0]  origin_z;
      logic [31:0]  angle_value;
      logic         has_name;
      logic         name_overflow;
   } rsp_type;

   localparam num_state_type NumIdle = '{phase: NUM_SKIP, negative: 1'b0, magnitude: '0};

   function automatic logic [7:0] kw_len(input key_type k);
      logic [7:0] len;
      case (k)
         KEY_CLASS:  len = 8'd9;
         KEY_ORIGIN: len = 8'd6;
         KEY_ANGLE:  len = 8'd5;
         default:    len = 8'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] kw_char(input key_type k, input logic [3:0] i);
      logic [71:0] text;
      logic [3:0]  len;
      case (k)
         KEY_CLASS:  begin text = "classname"; len = 4'd9; end
         KEY_ORIGIN: begin text = {24'h0, "origin"}; len = 4'd6; end
         KEY_ANGLE:  begin text = {32'h0, "angle"}; len = 4'd5; end
         default:    begin text = '0; len = 4'd1; end
      endcase
      // first character sits in the highest used byte
      return text[{len - 4'd1 - i, 3'b000} +: 8];
   endfunction

   function automatic logic [31:0] num_value(input num_state_type n);
      logic [31:0] mag;
      mag = {1'b0, n.magnitude};
      return n.negative ? 32'd0 - mag : mag;
   endfunction

endpackage

>>> rtl/etp_num.sv
// Integer reader step: advance the atoi-style state by one text byte.
// Depends on etp_pkg.
module etp_num (
   input  etp_pkg::num_state_type num_cur,
   input  logic [7:0]             text_byte,
   output etp_pkg::num_state_type num_nxt
);
   import etp_pkg::*;

   logic        is_digit;
   logic        is_ws;
   logic [34:0] prod;

   assign is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
   assign is_ws    = (text_byte == ChSpace) || ((text_byte >= 8'h09) && (text_byte <= 8'h0D));

   // mag * 10 + digit as two shifted adds
   assign prod = {1'b0, num_cur.magnitude, 3'b000} + {3'b000, num_cur.magnitude, 1'b0}
               + {31'd0, text_byte[3:0]};

   always_comb begin
      logic take_digit;
      num_nxt    = num_cur;
      take_digit = 1'b0;
      case (num_cur.phase)
         NUM_SKIP: begin
            if (is_ws) begin
               num_nxt = num_cur;
            end else if (text_byte == ChPlus) begin
               num_nxt.phase = NUM_SIGN;
            end else if (text_byte == ChMinus) begin
               num_nxt.phase    = NUM_SIGN;
               num_nxt.negative = 1'b1;
            end else begin
               take_digit = 1'b1;
            end
         end
         NUM_SIGN, NUM_DIGIT: take_digit = 1'b1;
         NUM_DONE:            num_nxt = num_cur;
         default:             num_nxt = num_cur;
      endcase
      if (take_digit) begin
         if (!is_digit) begin
            num_nxt.phase = NUM_DONE;
         end else begin
            num_nxt.phase     = NUM_DIGIT;
            num_nxt.magnitude = (prod > {4'd0, NumMax}) ? NumMax : prod[MagW-1:0];
         end
      end
   end

endmodule

>>> rtl/etp_core.sv
// Parser state registers and the per-byte update that forms each result word.
// Depends on etp_pkg and etp_num.
module etp_core #(
   parameter int NAME_LIMIT = etp_pkg::NameLimitDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       text_byte,
   output logic             emit,
   output etp_pkg::rsp_type rsp
);
   import etp_pkg::*;

   localparam int CntW = $clog2(NAME_LIMIT);
   localparam logic [CntW-1:0] CntLast = CntW'(NAME_LIMIT - 1);

   phase_type      phase_ff, phase_in;
   key_type        key_ff, key_in;
   logic [2:0]     match_ff, match_in;
   logic [7:0]     len_ff, len_in;
   num_state_type  num_ff, num_in, num_fed;
   logic [1:0]     field_ff, field_in;
   logic [31:0]    x_ff, x_in, y_ff, y_in, z_ff, z_in, angle_ff, angle_in;
   logic [CntW-1:0] count_ff, count_in;
   logic           seen_ff, seen_in, dropped_ff, dropped_in;

   etp_num u_num (
      .num_cur   (num_ff),
      .text_byte (text_byte),
      .num_nxt   (num_fed)
   );

   always_comb begin
      logic [31:0] v;
      phase_in   = phase_ff;
      key_in     = key_ff;
      match_in   = match_ff;
      len_in     = len_ff;
      num_in     = num_ff;
      field_in   = field_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      angle_in   = angle_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      dropped_in = dropped_ff;
      emit       = 1'b0;
      rsp        = '0;
      v          = num_value(num_ff);

      case (phase_ff)
         PH_OUT: begin
            if (text_byte == ChOpenBrace) begin
               phase_in   = PH_ENT;
               x_in       = '0;
               y_in       = '0;
               z_in       = '0;
               angle_in   = '0;
               count_in   = '0;
               seen_in    = 1'b0;
               dropped_in = 1'b0;
            end
         end
         PH_ENT: begin
            if (text_byte == ChQuote) begin
               phase_in = PH_STR;
               match_in = 3'b111;
               len_in   = '0;
               num_in   = NumIdle;
               field_in = '0;
               if (key_ff == KEY_ORIGIN) begin
                  x_in = '0;
                  y_in = '0;
                  z_in = '0;
               end
               if (key_ff == KEY_CLASS) begin
                  seen_in    = 1'b1;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  emit       = 1'b1;
                  rsp.kind   = KIND_NAME_BEGIN;
               end
            end else if (text_byte == ChCloseBrace) begin
               phase_in          = PH_OUT;
               emit              = 1'b1;
               rsp.kind          = KIND_ENTITY;
               rsp.origin_x      = x_ff;
               rsp.origin_y      = y_ff;
               rsp.origin_z      = z_ff;
               rsp.angle_value   = angle_ff;
               rsp.has_name      = seen_ff;
               rsp.name_overflow = dropped_ff;
            end
         end
         PH_STR: begin
            if (text_byte == ChQuote) begin
               phase_in = PH_ENT;
               // commit the value under the old key
               if (key_ff == KEY_ORIGIN) begin
                  case (field_ff)
                     2'd0:    x_in = v;
                     2'd1:    z_in = 32'd0 - v;
                     default: y_in = 32'd0 - v;
                  endcase
               end else if (key_ff == KEY_ANGLE) begin
                  angle_in = v;
               end
               // the closed string becomes the next key
               if (match_ff[0] && len_ff == kw_len(KEY_CLASS)) begin
                  key_in = KEY_CLASS;
               end else if (match_ff[1] && len_ff == kw_len(KEY_ORIGIN)) begin
                  key_in = KEY_ORIGIN;
               end else if (match_ff[2] && len_ff == kw_len(KEY_ANGLE)) begin
                  key_in = KEY_ANGLE;
               end else begin
                  key_in = KEY_NONE;
               end
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (len_ff >= kw_len(key_type'(k)) ||
                      text_byte != kw_char(key_type'(k), len_ff[3:0])) begin
                     match_in[k] = 1'b0;
                  end
               end
               if (len_ff != LenMax) begin
                  len_in = len_ff + 8'd1;
               end
               case (key_ff)
                  KEY_ORIGIN: begin
                     if (text_byte == ChSpace && field_ff != 2'd2) begin
                        case (field_ff)
                           2'd0:    x_in = v;
                           default: z_in = 32'd0 - v;
                        endcase
                        field_in = field_ff + 2'd1;
                        num_in   = NumIdle;
                     end else begin
                        num_in = num_fed;
                     end
                  end
                  KEY_ANGLE: num_in = num_fed;
                  KEY_CLASS: begin
                     if (count_ff < CntLast) begin
                        emit           = 1'b1;
                        rsp.kind       = KIND_NAME_BYTE;
                        rsp.name_char  = text_byte;
                        rsp.name_index = 8'(count_ff);
                        count_in       = count_ff + CntW'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  default: num_in = num_ff;
               endcase
            end
         end
         default: phase_in = PH_OUT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OUT;
         key_ff     <= KEY_NONE;
         match_ff   <= '0;
         len_ff     <= '0;
         num_ff     <= NumIdle;
         field_ff   <= '0;
         x_ff       <= '0;
         y_ff       <= '0;
         z_ff       <= '0;
         angle_ff   <= '0;
         count_ff   <= '0;
         seen_ff    <= 1'b0;
         dropped_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         key_ff     <= key_in;
         match_ff   <= match_in;
         len_ff     <= len_in;
         num_ff     <= num_in;
         field_ff   <= field_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         z_ff       <= z_in;
         angle_ff   <= angle_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

>>> rtl/entity_text_parser_unit.sv
// Top level of the entity text parser: input word register, parser core, result register.
// Depends on etp_pkg, etp_core (and through it etp_num).
//
//   channel | direction | tdata (low bit up)                                   | tuser
//   req_    | in        | text_byte[7:0]                                       | -
//   rsp_    | out       | name_char, name_index, origin_x, origin_y, origin_z, | kind[1:0]
//           |           | angle_value, has_name, name_overflow, 6 zero bits    |
//
// One text byte per cycle unless a result waits on a stalled rsp_ side. Each word is held in
// the input register, run through the parser core from there, and its result, if any, lands
// in the result register that drives rsp_tvalid. Synchronous active-high reset
// returns the parser to "outside entity" with the key memory at "unknown". A stalled rsp_
// side holds one result while one more input word is taken; words that produce no result
// keep flowing past a full result register.
module entity_text_parser_unit #(
   parameter int NAME_LIMIT = etp_pkg::NameLimitDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [etp_pkg::ReqDataW-1:0]  req_tdata,   // text_byte[7:0]
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [etp_pkg::RspDataW-1:0]  rsp_tdata,   // name_char[7:0], name_index[15:8],
                                                      // origin_x[47:16], origin_y[79:48],
                                                      // origin_z[111:80], angle[143:112],
                                                      // has_name[144], name_overflow[145]
   output logic [etp_pkg::RspUserW-1:0]  rsp_tuser    // kind[1:0]
);
   import etp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   rsp_type    core_rsp;
   logic       core_emit;
   logic       advance;
   logic       req_take;

   // Step the parser when the held word either makes no result or has a free slot.
   assign advance    = in_valid_ff && (!core_emit || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   etp_core #(
      .NAME_LIMIT (NAME_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .text_byte (in_byte_ff),
      .emit      (core_emit),
      .rsp       (core_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && core_emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata[7:0];
      end
      if (advance && core_emit) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {6'd0, out_ff.name_overflow, out_ff.has_name, out_ff.angle_value,
                        out_ff.origin_z, out_ff.origin_y, out_ff.origin_x,
                        out_ff.name_index, out_ff.name_char};

endmodule

>>> test/entity_text_parser_unit_test.sv
// Self-checking testbench for entity_text_parser_unit: text words in, name and entity words out.
// Depends on etp_pkg and the RTL top; a scoreboard class predicts every result word.
`timescale 1ns / 100ps

module entity_text_parser_unit_test;
   import etp_pkg::*;

   localparam int ClockPeriod   = 12;
   localparam int NameLimit     = NameLimitDefault;
   localparam int ItemsTarget   = 1100;
   localparam int TailItems     = 150;
   localparam int ResultLatency = 2;
   localparam int CycleLimit    = 400000;
   localparam logic [31:0] MagnitudeMax = 32'h7FFF_FFFF;

   // Tracks the parser state word by word and keeps the result words it owes.
   class entity_scoreboard;
      rsp_type       owed_q[$];
      int            failures;
      int            results;
      int            records;
      int            dropped_records;
      string         keyword[3];
      phase_type     phase;
      key_type       key;
      logic [2:0]    match;
      int            slen;
      num_phase_type nphase;
      bit            neg;
      logic [31:0]   mag;
      int            ofield;
      logic [31:0]   ox, oy, oz, ang;
      int            ncount;
      bit            seen, dropped;

      function new();
         keyword = '{"classname", "origin", "angle"};
         phase   = PH_OUT;
         key     = KEY_NONE;
         match   = '0;
         slen    = 0;
         clear_number();
         ofield  = 0;
         ox = '0; oy = '0; oz = '0; ang = '0;
         ncount  = 0;
         seen    = 0;
         dropped = 0;
      endfunction

      function void clear_number();
         nphase = NUM_SKIP;
         neg    = 0;
         mag    = '0;
      endfunction

      function logic [31:0] number_value();
         return neg ? 32'd0 - mag : mag;
      endfunction

      function void feed_number(logic [7:0] c);
         bit              is_digit;
         longint unsigned grown;
         is_digit = c >= 8'h30 && c <= 8'h39;
         if (nphase == NUM_SKIP) begin
            if (c == ChSpace || (c >= 8'd9 && c <= 8'd13)) return;
            if (c == ChPlus) begin
               nphase = NUM_SIGN;
               return;
            end
            if (c == ChMinus) begin
               neg    = 1;
               nphase = NUM_SIGN;
               return;
            end
         end
         if (nphase == NUM_DONE) return;
         if (!is_digit) begin
            nphase = NUM_DONE;
            return;
         end
         grown  = longint'(mag) * 10 + longint'(c - 8'h30);
         mag    = grown > longint'(MagnitudeMax) ? MagnitudeMax : 32'(grown);
         nphase = NUM_DIGIT;
      endfunction

      function void commit_origin();
         logic [31:0] v;
         v = number_value();
         case (ofield)
            0:       ox = v;
            1:       oz = 32'd0 - v;
            default: oy = 32'd0 - v;
         endcase
      endfunction

      function void push_result(kind_type kind, logic [7:0] ch, logic [7:0] idx, bit rec);
         rsp_type r;
         r.kind          = kind;
         r.name_char     = ch;
         r.name_index    = idx;
         r.origin_x      = rec ? ox : 32'd0;
         r.origin_y      = rec ? oy : 32'd0;
         r.origin_z      = rec ? oz : 32'd0;
         r.angle_value   = rec ? ang : 32'd0;
         r.has_name      = rec & seen;
         r.name_overflow = rec & dropped;
         owed_q.insert(owed_q.size(), r);
      endfunction

      // Advance the parser by one accepted text word.
      function void note_text(logic [7:0] c);
         if (phase == PH_OUT) begin
            if (c == ChOpenBrace) begin
               phase = PH_ENT;
               ox = '0; oy = '0; oz = '0; ang = '0;
               ncount  = 0;
               seen    = 0;
               dropped = 0;
            end
            return;
         end
         if (phase == PH_ENT) begin
            if (c == ChQuote) begin
               phase  = PH_STR;
               match  = 3'b111;
               slen   = 0;
               clear_number();
               ofield = 0;
               if (key == KEY_ORIGIN) begin
                  ox = '0; oy = '0; oz = '0;
               end
               if (key == KEY_CLASS) begin
                  seen    = 1;
                  ncount  = 0;
                  dropped = 0;
                  push_result(KIND_NAME_BEGIN, 8'd0, 8'd0, 0);
               end
            end else if (c == ChCloseBrace) begin
               phase = PH_OUT;
               push_result(KIND_ENTITY, 8'd0, 8'd0, 1);
            end
            return;
         end
         // inside a string
         if (c == ChQuote) begin
            phase = PH_ENT;
            if (key == KEY_ORIGIN) commit_origin();
            else if (key == KEY_ANGLE) ang = number_value();
            key = KEY_NONE;
            for (int k = 0; k < 3; k++) begin
               if (match[k] && slen == keyword[k].len()) begin
                  key = key_type'(k);
                  break;
               end
            end
            return;
         end
         for (int k = 0; k < 3; k++) begin
            if (match[k] && (slen >= keyword[k].len() || c != 8'(keyword[k][slen])))
               match[k] = 1'b0;
         end
         if (slen < int'(LenMax)) slen++;
         if (key == KEY_ORIGIN) begin
            if (c == ChSpace && ofield < 2) begin
               commit_origin();
               ofield++;
               clear_number();
            end else begin
               feed_number(c);
            end
         end else if (key == KEY_ANGLE) begin
            feed_number(c);
         end else if (key == KEY_CLASS) begin
            if (ncount < NameLimit - 1) begin
               push_result(KIND_NAME_BYTE, c, 8'(ncount), 0);
               ncount++;
            end else begin
               dropped = 1;
            end
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d (0x%0h), actual %0d (0x%0h)",
                   field, $signed(want), want, $signed(got), got);
            failures++;
         end
      endfunction

      // Check one accepted result word against the oldest owed one.
      function void check_result(logic [RspUserW-1:0] user, logic [RspDataW-1:0] data);
         rsp_type want;
         if (owed_q.size() == 0) begin
            $error("result word with none expected: kind %0d", user);
            failures++;
            return;
         end
         want = owed_q.pop_front();
         results++;
         if (user == KIND_ENTITY) records++;
         if (data[145]) dropped_records++;
         compare_field("kind",          32'(want.kind),          32'(user));
         compare_field("name_char",     32'(want.name_char),     32'(data[7:0]));
         compare_field("name_index",    32'(want.name_index),    32'(data[15:8]));
         compare_field("origin_x",      want.origin_x,           data[47:16]);
         compare_field("origin_y",      want.origin_y,           data[79:48]);
         compare_field("origin_z",      want.origin_z,           data[111:80]);
         compare_field("angle_value",   want.angle_value,        data[143:112]);
         compare_field("has_name",      32'(want.has_name),      32'(data[144]));
         compare_field("name_overflow", 32'(want.name_overflow), 32'(data[145]));
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [RspUserW-1:0] rsp_tuser;

   entity_scoreboard book = new();
   bit idle_on      = 1;
   int stall_left   = 0;
   int cycle_count  = 0;
   int words_total  = 0;
   int words_inside = 0;
   int entities     = 0;

   entity_text_parser_unit #(.NAME_LIMIT(NameLimit)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Bail out if the run hangs; the bound covers worst-case gaps and stalls many times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles, %0d result words still owed",
                  cycle_count, book.owed_q.size());
         $display("FAIL entity_text_parser_unit");
         $finish;
      end
   end

   // Result side: stall in random bursts while idling is on, change at the falling edge.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Sample the result handshake at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tuser, rsp_tdata);
   end

   // Offer one text word at the falling edge, hold it until taken, then note it.
   // Entered and left at a falling edge; a random gap may precede the word.
   task automatic send_word(input logic [7:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      words_total++;
      if (book.phase != PH_OUT) words_inside++;
      book.note_text(b);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_word(8'(s[i]));
   endtask

   // Hold the sender off until every owed result word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (book.owed_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] free_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == ChQuote || b == ChCloseBrace) b = ChSpace;
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(0, 2) == 0) ? 8'(8'd9 + $urandom_range(0, 4)) : ChSpace;
   endfunction

   // Whitespace, stray open braces and junk between strings.
   task automatic send_filler();
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 5))
            0:       send_word(ChOpenBrace);
            1:       send_word(free_byte());
            default: send_word(blank_byte());
         endcase
      end
   endtask

   // Optional blanks and sign, then digits; long runs hit saturation, a dot ends it early.
   task automatic send_number();
      int ndig;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) send_word(blank_byte());
      case ($urandom_range(0, 3))
         0:       send_word(ChMinus);
         1:       send_word(ChPlus);
         default: ;
      endcase
      ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
      repeat (ndig) send_word(8'(8'h30 + $urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) send_word(8'h2E);
   endtask

   task automatic send_name_body(input int len);
      repeat (len) begin
         if ($urandom_range(0, 3) == 0) send_word(free_byte());
         else send_word(8'($urandom_range(8'h21, 8'h7E)));
      end
   endtask

   function automatic string odd_key();
      case ($urandom_range(0, 7))
         0:       return "target";
         1:       return "origi";
         2:       return "originx";
         3:       return "angles";
         4:       return "class";
         5:       return "classnamex";
         6:       return "Origin";
         default: return "";
      endcase
   endfunction

   // One quoted value shaped for the key in front of it; sometimes a keyword instead.
   task automatic send_value(input key_type k, input bit long_name);
      int fields;
      if (!long_name && $urandom_range(0, 7) == 0) begin
         send_text({"\"", book.keyword[$urandom_range(0, 2)], "\""});
         return;
      end
      send_word(ChQuote);
      case (k)
         KEY_CLASS: begin
            if (long_name) begin
               repeat ($urandom_range(NameLimit, NameLimit + 16))
                  send_word(8'($urandom_range(8'h61, 8'h7A)));
            end else begin
               send_name_body($urandom_range(0, 12));
            end
         end
         KEY_ORIGIN: begin
            fields = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 3;
            for (int i = 0; i < fields; i++) begin
               if (i > 0) begin
                  send_word(ChSpace);
                  if ($urandom_range(0, 9) == 0) send_word(ChSpace);
               end
               send_number();
            end
         end
         KEY_ANGLE: send_number();
         default:   send_name_body($urandom_range(0, 8));
      endcase
      send_word(ChQuote);
   endtask

   // One entity of key/value pairs with random content; now and then a value goes missing.
   task automatic send_entity(input bit long_name);
      key_type k;
      send_word(ChOpenBrace);
      send_filler();
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 7))
            0, 1:    k = KEY_CLASS;
            2, 3:    k = KEY_ORIGIN;
            4, 5:    k = KEY_ANGLE;
            default: k = KEY_NONE;
         endcase
         if (long_name) k = KEY_CLASS;
         if (k == KEY_NONE) send_text({"\"", odd_key(), "\""});
         else send_text({"\"", book.keyword[k], "\""});
         send_filler();
         if (long_name || $urandom_range(0, 11) != 0) begin
            send_value(k, long_name);
            send_filler();
         end
         long_name = 0;
      end
      send_word(ChCloseBrace);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme bytes, a stray close brace and a quote outside an entity are dropped.
      send_word(8'h00);
      send_word(8'hFF);
      send_word(ChCloseBrace);
      send_word(ChQuote);
      // Class name holding braces, a NUL and an all-ones byte.
      send_text("{\"classname\" \"a{}");
      send_word(8'h00);
      send_word(8'hFF);
      send_text("\"}");
      // Full origin and angle, with a stray open brace inside the entity.
      send_text("{{\"origin\" \"-12 34 +56\" \"angle\" \"-90\"}");
      // Missing origin fields, empty field, extra text in the third field, saturation.
      send_text("{\"origin\" \"7\" \"angle\" \"2147483647\"}");
      send_text("{\"origin\" \"1  -2 3 4\" \"angle\" \"99999999999\"}");
      send_text("{\"angle\" \" \t+ 5\" \"origin\" \"-2147483648 x9 +\"}");
      // Key memory across entities, and a class name restarted within one.
      send_text("{\"classname\"}{\"ab\" \"classname\" \"cd\"}");
      drain_results();

      // Random: mostly well-formed entities, some noise outside them.
      while (words_inside < ItemsTarget) begin
         idle_on = (words_inside > ItemsTarget - TailItems) ? 0 : ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_word(free_byte());
         end
         send_entity(entities == 2);
         entities++;
         if (entities == 20) drain_results();
      end

      drain_results();
      repeat (ResultLatency + 4) @(negedge clock);

      $display("Sent %0d text words (%0d inside entities) over %0d random entities.",
               words_total, words_inside, entities);
      $display("Checked %0d result words: %0d entity records, %0d with a truncated name.",
               book.results, book.records, book.dropped_records);
      if (book.failures == 0) begin
         $display("PASS entity_text_parser_unit");
      end else begin
         $display("FAIL entity_text_parser_unit");
      end
      $finish;
   end

endmodule
